// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the port checker of the fin actuator.
// Depends on nothing; include it with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the clock after the antecedent.
`define SFA_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fin actuator checker: next-cycle property failed");

// Consequent must hold in the same clock as the antecedent.
`define SFA_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fin actuator checker: same-cycle property failed");

`endif

// ===== hw/rtl/sfa_pkg.sv =====
// Shared types and constants for the second-order fin actuator.
// Used by the multiplier unit, the top level and the port checker.
package sfa_pkg;

   localparam int DATA_W     = 32;
   localparam int OPND_W     = 33;
   localparam int PROD_W     = 2 * OPND_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 31;

   // Rescale shifts fixed by the register formats.
   localparam int TRAP_SHIFT  = 25;
   localparam int STIFF_SHIFT = 16;
   localparam int DAMP_SHIFT  = 19;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DYNAMICS_MODE,
      CSR_POSITION_LIMIT,
      CSR_RATE_LIMIT,
      CSR_NATURAL_FREQ,
      CSR_DAMPING_RATIO,
      CSR_TIME_STEP
   } csr_index_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] aileron_cmd;
      logic signed [DATA_W-1:0] elevator_cmd;
      logic signed [DATA_W-1:0] rudder_cmd;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] aileron_out;
      logic signed [DATA_W-1:0] elevator_out;
      logic signed [DATA_W-1:0] rudder_out;
      logic signed [DATA_W-1:0] left_elevon;
      logic signed [DATA_W-1:0] right_elevon;
      logic signed [DATA_W-1:0] left_elevon_cmd;
      logic signed [DATA_W-1:0] right_elevon_cmd;
   } rsp_type;

   // Operand load request from the sequencer to the shared multiplier.
   typedef struct packed {
      logic                     load;
      logic signed [OPND_W-1:0] a;
      logic signed [OPND_W-1:0] b;
   } mul_op_type;

endpackage

// ===== hw/rtl/sfa_mul.sv =====
// Shared signed multiplier with registered operands and registered product.
// Depends on sfa_pkg for the operand request type and widths.
module sfa_mul import sfa_pkg::*; (
   input  logic                     clock,
   input  mul_op_type               op_in,
   output logic signed [PROD_W-1:0] prod_ff
);

   logic signed [OPND_W-1:0] op_a_ff;
   logic signed [OPND_W-1:0] op_b_ff;
   logic signed [OPND_W-1:0] op_a_in;
   logic signed [OPND_W-1:0] op_b_in;
   logic signed [PROD_W-1:0] prod_in;

   // Loaded operands are held in the operand registers; their product is registered from those.
   always_comb begin
      op_a_in = op_in.load ? op_in.a : op_a_ff;
      op_b_in = op_in.load ? op_in.b : op_b_ff;
      prod_in = op_a_ff * op_b_ff;
   end

   always_ff @(posedge clock) begin
      op_a_ff <= op_a_in;
      op_b_ff <= op_b_in;
      prod_ff <= prod_in;
   end

endmodule

// ===== hw/rtl/second_order_fin_actuator.sv =====
// Clamp mode steps through the clamp and finish states; dynamics mode forms the gains first,
// then takes each surface through its clamps, trapezoid steps and stiffness and damping terms,
// with the sequencer stepping the one shared multiplier through the three surfaces in turn.
// The input is stalled while an item is in work; a finished result waits in the output register.
// Reset is synchronous and active high: it clears the registers, the fin state and the handshake.
module second_order_fin_actuator import sfa_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_payload,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // Surfaces are handled in the order left elevon, right elevon, rudder.
   localparam int         NSURF     = 3;
   localparam logic [1:0] SURF_LAST = 2'(NSURF - 1);

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CLAMP,
      ST_GAIN_A,
      ST_GAIN_B,
      ST_GAIN_C,
      ST_PCLAMP,
      ST_RCLAMP,
      ST_TRAP1_OP,
      ST_TRAP1_MUL,
      ST_POS,
      ST_ERR,
      ST_STIFF_MUL,
      ST_ACC,
      ST_TRAP2_OP,
      ST_TRAP2_MUL,
      ST_RATE,
      ST_FINISH
   } state_type;

   typedef logic signed [DATA_W-1:0] word_type;

   localparam logic signed [PROD_W-1:0] WIDE_MAX = $signed({{(PROD_W-31){1'b0}}, {31{1'b1}}});
   localparam logic signed [PROD_W-1:0] WIDE_MIN = $signed({{(PROD_W-31){1'b1}}, 31'd0});

   // Saturate a wide signed value to the 32-bit data range.
   function automatic word_type sat32(input logic signed [PROD_W-1:0] v);
      word_type r;
      if (v > WIDE_MAX) begin
         r = WIDE_MAX[DATA_W-1:0];
      end else if (v < WIDE_MIN) begin
         r = WIDE_MIN[DATA_W-1:0];
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

   // Clamp a value to plus or minus an unsigned magnitude limit.
   function automatic word_type clamp_mag(input word_type v, input logic [CSR_DATA_W-1:0] lim);
      word_type hi;
      word_type lo;
      word_type r;
      hi = $signed({1'b0, lim});
      lo = -hi;
      if (v > hi) begin
         r = hi;
      end else if (v < lo) begin
         r = lo;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // True when both values are strictly positive or both strictly negative.
   function automatic logic same_sign(input word_type a, input word_type b);
      logic a_pos;
      logic b_pos;
      a_pos = !a[DATA_W-1] && (a != '0);
      b_pos = !b[DATA_W-1] && (b != '0);
      return (a_pos && b_pos) || (a[DATA_W-1] && b[DATA_W-1]);
   endfunction

   // Control, configuration, fin state and the output register.
   state_type                     state_ff,     state_in;
   logic [1:0]                    surf_ff,      surf_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   rsp_type                       rsp_payload_ff, rsp_payload_in;
   logic                          mode_ff,      mode_in;
   logic [CSR_DATA_W-1:0]         pos_limit_ff, pos_limit_in;
   logic [CSR_DATA_W-1:0]         rate_limit_ff, rate_limit_in;
   logic [15:0]                   nat_freq_ff,  nat_freq_in;
   logic [15:0]                   damping_ff,   damping_in;
   logic [23:0]                   time_step_ff, time_step_in;
   word_type                      fin_pos_ff  [NSURF];
   word_type                      fin_pos_in  [NSURF];
   word_type                      fin_pdp_ff  [NSURF];
   word_type                      fin_pdp_in  [NSURF];
   word_type                      fin_rate_ff [NSURF];
   word_type                      fin_rate_in [NSURF];
   word_type                      fin_rdp_ff  [NSURF];
   word_type                      fin_rdp_in  [NSURF];

   // Working registers of the item in flight.
   word_type                      cmd_ff [NSURF];
   word_type                      cmd_in [NSURF];
   word_type                      act_ff [NSURF];
   word_type                      act_in [NSURF];
   word_type                      pos_w_ff,  pos_w_in;
   word_type                      rate_w_ff, rate_w_in;
   logic                          lim_ff,    lim_in;
   logic [DATA_W-1:0]             wn2_ff,    wn2_in;
   logic [DATA_W-1:0]             zw_ff,     zw_in;
   word_type                      dterm_ff,  dterm_in;
   word_type                      acc_ff,    acc_in;

   mul_op_type                    mul_op;
   logic signed [PROD_W-1:0]      mul_prod;

   word_type                      pos_rd;
   word_type                      rate_rd;
   word_type                      pos_c;
   word_type                      rate_c;
   word_type                      rate_new;
   logic signed [DATA_W:0]        mix_diff;
   logic signed [DATA_W:0]        mix_sum;

   sfa_mul u_mul (
      .clock   (clock),
      .op_in   (mul_op),
      .prod_ff (mul_prod)
   );

   assign req_stall   = (state_ff != ST_IDLE);
   assign csr_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Values looked at by the per-surface steps.
   assign pos_rd   = fin_pos_ff[surf_ff];
   assign rate_rd  = fin_rate_ff[surf_ff];
   assign pos_c    = clamp_mag(pos_rd, pos_limit_ff);
   assign rate_c   = clamp_mag(rate_w_ff, rate_limit_ff);
   assign rate_new = sat32(PROD_W'(rate_w_ff) + (mul_prod >>> TRAP_SHIFT));
   assign mix_diff = (DATA_W+1)'(act_ff[0]) - (DATA_W+1)'(act_ff[1]);
   assign mix_sum  = (DATA_W+1)'(act_ff[0]) + (DATA_W+1)'(act_ff[1]);

   always_comb begin
      state_in       = state_ff;
      surf_in        = surf_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      mode_in        = mode_ff;
      pos_limit_in   = pos_limit_ff;
      rate_limit_in  = rate_limit_ff;
      nat_freq_in    = nat_freq_ff;
      damping_in     = damping_ff;
      time_step_in   = time_step_ff;
      fin_pos_in     = fin_pos_ff;
      fin_pdp_in     = fin_pdp_ff;
      fin_rate_in    = fin_rate_ff;
      fin_rdp_in     = fin_rdp_ff;
      cmd_in         = cmd_ff;
      act_in         = act_ff;
      pos_w_in       = pos_w_ff;
      rate_w_in      = rate_w_ff;
      lim_in         = lim_ff;
      wn2_in         = wn2_ff;
      zw_in          = zw_ff;
      dterm_in       = dterm_ff;
      acc_in         = acc_ff;
      mul_op         = '{load: 1'b0, a: '0, b: '0};

      // The waiting result leaves on its output transfer.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // Register writes; they only arrive while no item is in work.
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DYNAMICS_MODE:  mode_in       = csr_data[0];
            CSR_POSITION_LIMIT: pos_limit_in  = csr_data;
            CSR_RATE_LIMIT:     rate_limit_in = csr_data;
            CSR_NATURAL_FREQ:   nat_freq_in   = csr_data[15:0];
            CSR_DAMPING_RATIO:  damping_in    = csr_data[15:0];
            CSR_TIME_STEP:      time_step_in  = csr_data[23:0];
            default:            ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               // Elevon mixing: elevator plus and minus aileron, saturated.
               cmd_in[0] = sat32(PROD_W'(req_payload.elevator_cmd)
                                 + PROD_W'(req_payload.aileron_cmd));
               cmd_in[1] = sat32(PROD_W'(req_payload.elevator_cmd)
                                 - PROD_W'(req_payload.aileron_cmd));
               cmd_in[2] = req_payload.rudder_cmd;
               surf_in   = '0;
               if (mode_ff) begin
                  mul_op   = '{load: 1'b1, a: {17'd0, nat_freq_ff}, b: {17'd0, nat_freq_ff}};
                  state_in = ST_GAIN_A;
               end else begin
                  state_in = ST_CLAMP;
               end
            end
         end
         ST_CLAMP: begin
            for (int k = 0; k < NSURF; k++) begin
               act_in[k] = clamp_mag(cmd_ff[k], pos_limit_ff);
            end
            state_in = ST_FINISH;
         end
         ST_GAIN_A: begin
            mul_op   = '{load: 1'b1, a: {17'd0, damping_ff}, b: {17'd0, nat_freq_ff}};
            state_in = ST_GAIN_B;
         end
         ST_GAIN_B: begin
            wn2_in   = mul_prod[DATA_W-1:0];
            state_in = ST_GAIN_C;
         end
         ST_GAIN_C: begin
            zw_in    = mul_prod[DATA_W-1:0];
            state_in = ST_PCLAMP;
         end
         ST_PCLAMP: begin
            // A position pulled back to the limit stops any rate pushing further out.
            pos_w_in = pos_c;
            if ((pos_c != pos_rd) && same_sign(pos_c, rate_rd)) begin
               rate_w_in = '0;
            end else begin
               rate_w_in = rate_rd;
            end
            state_in = ST_RCLAMP;
         end
         ST_RCLAMP: begin
            lim_in    = (rate_c != rate_w_ff);
            rate_w_in = rate_c;
            state_in  = ST_TRAP1_OP;
         end
         ST_TRAP1_OP: begin
            mul_op   = '{load: 1'b1,
                         a: OPND_W'(rate_w_ff) + OPND_W'(fin_pdp_ff[surf_ff]),
                         b: {9'd0, time_step_ff}};
            state_in = ST_TRAP1_MUL;
         end
         ST_TRAP1_MUL: begin
            // The damping product is queued behind the position step.
            mul_op   = '{load: 1'b1, a: OPND_W'(rate_w_ff), b: {1'b0, zw_ff}};
            state_in = ST_POS;
         end
         ST_POS: begin
            pos_w_in            = sat32(PROD_W'(pos_w_ff) + (mul_prod >>> TRAP_SHIFT));
            fin_pdp_in[surf_ff] = rate_w_ff;
            state_in            = ST_ERR;
         end
         ST_ERR: begin
            dterm_in = sat32(mul_prod >>> DAMP_SHIFT);
            mul_op   = '{load: 1'b1,
                         a: OPND_W'(sat32(PROD_W'(cmd_ff[surf_ff]) - PROD_W'(pos_w_ff))),
                         b: {1'b0, wn2_ff}};
            state_in = ST_STIFF_MUL;
         end
         ST_STIFF_MUL: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            acc_in   = sat32(PROD_W'(sat32(mul_prod >>> STIFF_SHIFT)) - PROD_W'(dterm_ff));
            state_in = ST_TRAP2_OP;
         end
         ST_TRAP2_OP: begin
            mul_op   = '{load: 1'b1,
                         a: OPND_W'(acc_ff) + OPND_W'(fin_rdp_ff[surf_ff]),
                         b: {9'd0, time_step_ff}};
            state_in = ST_TRAP2_MUL;
         end
         ST_TRAP2_MUL: begin
            state_in = ST_RATE;
         end
         ST_RATE: begin
            fin_rate_in[surf_ff] = rate_new;
            fin_pos_in[surf_ff]  = pos_w_ff;
            act_in[surf_ff]      = pos_w_ff;
            // A rate that was limited drops the stored acceleration when both push the same way.
            if (lim_ff && same_sign(rate_new, acc_ff)) begin
               fin_rdp_in[surf_ff] = '0;
            end else begin
               fin_rdp_in[surf_ff] = acc_ff;
            end
            if (surf_ff == SURF_LAST) begin
               state_in = ST_FINISH;
            end else begin
               surf_in  = surf_ff + 2'd1;
               state_in = ST_PCLAMP;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_payload_in.aileron_out      = mix_diff[DATA_W:1];
               rsp_payload_in.elevator_out     = mix_sum[DATA_W:1];
               rsp_payload_in.rudder_out       = act_ff[2];
               rsp_payload_in.left_elevon      = act_ff[0];
               rsp_payload_in.right_elevon     = act_ff[1];
               rsp_payload_in.left_elevon_cmd  = cmd_ff[0];
               rsp_payload_in.right_elevon_cmd = cmd_ff[1];
               rsp_valid_in                    = 1'b1;
               state_in                        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer state, configuration, fin state and the registered result.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         surf_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         mode_ff       <= 1'b0;
         pos_limit_ff  <= '0;
         rate_limit_ff <= '0;
         nat_freq_ff   <= '0;
         damping_ff    <= '0;
         time_step_ff  <= '0;
         fin_pos_ff    <= '{default: '0};
         fin_pdp_ff    <= '{default: '0};
         fin_rate_ff   <= '{default: '0};
         fin_rdp_ff    <= '{default: '0};
      end else begin
         state_ff       <= state_in;
         surf_ff        <= surf_in;
         rsp_valid_ff   <= rsp_valid_in;
         rsp_payload_ff <= rsp_payload_in;
         mode_ff        <= mode_in;
         pos_limit_ff   <= pos_limit_in;
         rate_limit_ff  <= rate_limit_in;
         nat_freq_ff    <= nat_freq_in;
         damping_ff     <= damping_in;
         time_step_ff   <= time_step_in;
         fin_pos_ff     <= fin_pos_in;
         fin_pdp_ff     <= fin_pdp_in;
         fin_rate_ff    <= fin_rate_in;
         fin_rdp_ff     <= fin_rdp_in;
      end
   end

   // Working values of the item in flight need no reset.
   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      act_ff    <= act_in;
      pos_w_ff  <= pos_w_in;
      rate_w_ff <= rate_w_in;
      lim_ff    <= lim_in;
      wn2_ff    <= wn2_in;
      zw_ff     <= zw_in;
      dterm_ff  <= dterm_in;
      acc_ff    <= acc_in;
   end

endmodule

// ===== hw/rtl/sfa_checker.sv =====
// Port-level checker for the fin actuator, bound to the top level.
// Depends on sfa_pkg and on the macros in assert_macros.svh.
`include "assert_macros.svh"

module sfa_checker import sfa_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input rsp_type               rsp_payload
);

   // A stalled result stays offered and unchanged.
   `SFA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))

   // An accepted item keeps the block busy in the following cycle.
   `SFA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   // A new result only appears at the end of work, while the input was stalled.
   `SFA_ASSERT_NOW(a_result_from_work, clock, reset, $rose(rsp_valid), $past(req_stall))

endmodule

bind second_order_fin_actuator sfa_checker u_sfa_checker (.*);

// ===== tb/second_order_fin_actuator_test.sv =====
// Self-checking bench for the second-order fin actuator: clamp and dynamics modes.
// Drives commands through a queue-fed driver, predicts each result in a local model.
// Depends on sfa_pkg for the payload structs and register indexes, and on the block itself.
module second_order_fin_actuator_test;
   import sfa_pkg::*;

   localparam int CLOCK_HALF    = 2;
   localparam int RESET_CYCLES  = 7;
   localparam int RUN_LIMIT     = 2_000_000;  // time units
   localparam int DRAIN_CYCLES  = 60;         // comfortably past the dynamics latency
   localparam int BURST_CYCLES  = 400;
   localparam int SETTING_COUNT = 12;
   localparam int ITEMS_PER_SETTING = 82;
   localparam int MAX_REPORTS   = 10;
   localparam int NUM_SURFACES  = 3;

   localparam logic MODE_CLAMP    = 1'b0;
   localparam logic MODE_DYNAMICS = 1'b1;

   // Fixed-point rescale shifts of the actuator arithmetic.
   localparam int MEAN_STEP_SHIFT = 25;  // Q0.24 step times half the sum
   localparam int STIFF_SHIFT_TB  = 16;  // Q16.16 wn^2 times Q16.16 error
   localparam int DAMP_SHIFT_TB   = 19;  // Q12.20 zeta*wn times rate, doubled

   localparam longint WORD_MAX = 64'sd2147483647;
   localparam longint WORD_MIN = -64'sd2147483648;
   localparam int DEG = 1 << 16;
   localparam int NEAR_SPAN = 60 * DEG;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data  = '0;

   second_order_fin_actuator dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always #CLOCK_HALF clock = ~clock;

   // Commands waiting to be offered, and results predicted for accepted commands.
   req_type pending_commands[$];
   rsp_type predicted_deflections[$];

   int sender_idle_pct   = 0;
   int receiver_idle_pct = 0;
   int commands_accepted = 0;
   int results_checked   = 0;
   int error_count       = 0;
   int settings_applied  = 0;

   // Long receiver hold-off: the stimulus bumps the request count, the counter
   // process below turns that into a stretch of stalled cycles.
   int burst_request = 0;
   int burst_seen    = 0;
   int burst_left    = 0;

   // ---------------------------------------------------------------------
   // Local copy of the actuator: registers and per-surface dynamic state.
   // Surface 0 is the left elevon, 1 the right elevon, 2 the rudder.
   // ---------------------------------------------------------------------
   logic   cfg_mode      = MODE_CLAMP;
   longint cfg_pos_limit = 0;
   longint cfg_rate_limit = 0;
   longint cfg_wn        = 0;
   longint cfg_zeta      = 0;
   longint cfg_dt        = 0;

   longint fin_pos[NUM_SURFACES]         = '{default: 0};
   longint pos_slope_prev[NUM_SURFACES]  = '{default: 0};
   longint fin_rate[NUM_SURFACES]        = '{default: 0};
   longint rate_slope_prev[NUM_SURFACES] = '{default: 0};

   function automatic longint sat_word(longint v);
      if (v > WORD_MAX) return WORD_MAX;
      if (v < WORD_MIN) return WORD_MIN;
      return v;
   endfunction

   function automatic longint limit_mag(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic bit same_sign(longint a, longint b);
      return (a > 0 && b > 0) || (a < 0 && b < 0);
   endfunction

   // Trapezoidal increment: step times the mean of the new and old slope, floored.
   function automatic longint trapezoid(longint now_slope, longint old_slope);
      return ((now_slope + old_slope) * cfg_dt) >>> MEAN_STEP_SHIFT;
   endfunction

   function automatic logic [DATA_W-1:0] word_of(longint v);
      return v[DATA_W-1:0];
   endfunction

   // One tick of the second-order lag for one surface; returns the new deflection.
   function automatic longint advance_surface(int s, longint cmd);
      longint pos, rate, stiff, damp, err, accel;
      bit     rate_clipped;
      pos = fin_pos[s];
      rate = fin_rate[s];
      rate_clipped = 1'b0;
      // A position left beyond the limit by the last tick is pulled back first;
      // a rate still driving it outward is dropped.
      if (pos > cfg_pos_limit || pos < -cfg_pos_limit) begin
         pos = limit_mag(pos, cfg_pos_limit);
         if (same_sign(pos, rate)) rate = 0;
      end
      if (rate > cfg_rate_limit || rate < -cfg_rate_limit) begin
         rate_clipped = 1'b1;
         rate = limit_mag(rate, cfg_rate_limit);
      end
      pos = sat_word(pos + trapezoid(rate, pos_slope_prev[s]));
      pos_slope_prev[s] = rate;
      err = sat_word(cmd - pos);
      stiff = cfg_wn * cfg_wn;
      damp = cfg_zeta * cfg_wn;
      accel = sat_word(sat_word((stiff * err) >>> STIFF_SHIFT_TB)
                       - sat_word((damp * rate) >>> DAMP_SHIFT_TB));
      rate = sat_word(rate + trapezoid(accel, rate_slope_prev[s]));
      rate_slope_prev[s] = accel;
      if (rate_clipped && same_sign(rate, accel)) rate_slope_prev[s] = 0;
      fin_pos[s] = pos;
      fin_rate[s] = rate;
      return pos;
   endfunction

   function automatic rsp_type predict_deflections(req_type c);
      longint  ail, elv;
      longint  surf_cmd[NUM_SURFACES];
      longint  achieved[NUM_SURFACES];
      rsp_type r;
      ail = longint'($signed(c.aileron_cmd));
      elv = longint'($signed(c.elevator_cmd));
      surf_cmd[0] = sat_word(elv + ail);
      surf_cmd[1] = sat_word(elv - ail);
      surf_cmd[2] = longint'($signed(c.rudder_cmd));
      // Clamp mode neither reads nor touches the dynamic state.
      for (int s = 0; s < NUM_SURFACES; s++)
         achieved[s] = (cfg_mode == MODE_CLAMP) ? limit_mag(surf_cmd[s], cfg_pos_limit)
                                                : advance_surface(s, surf_cmd[s]);
      r.aileron_out      = word_of((achieved[0] - achieved[1]) >>> 1);
      r.elevator_out     = word_of((achieved[0] + achieved[1]) >>> 1);
      r.rudder_out       = word_of(achieved[2]);
      r.left_elevon      = word_of(achieved[0]);
      r.right_elevon     = word_of(achieved[1]);
      r.left_elevon_cmd  = word_of(surf_cmd[0]);
      r.right_elevon_cmd = word_of(surf_cmd[1]);
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Driver: offers queued commands, holds a stalled payload steady, and
   // advances the local model on every accepted transfer. An idle driver offers without
   // looking at the stall; the stall only tells whether an offered command moves or is held.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predicted_deflections.push_back(predict_deflections(req_payload));
            commands_accepted++;
         end
         if (req_valid && req_stall) begin
            // Stalled: keep valid and payload as they are.
         end else if (pending_commands.size() != 0
                      && $urandom_range(99) >= sender_idle_pct) begin
            req_valid   <= 1'b1;
            req_payload <= pending_commands.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: every result transfer is matched against the oldest prediction.
   // ---------------------------------------------------------------------
   task automatic compare_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      if (want !== got) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("result %0d: %s expected %h, got %h", results_checked, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_deflections.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("unexpected result transfer %h with nothing outstanding",
                           rsp_payload);
            end else begin
               rsp_type want;
               want = predicted_deflections.pop_front();
               compare_field("aileron_out", want.aileron_out, rsp_payload.aileron_out);
               compare_field("elevator_out", want.elevator_out, rsp_payload.elevator_out);
               compare_field("rudder_out", want.rudder_out, rsp_payload.rudder_out);
               compare_field("left_elevon", want.left_elevon, rsp_payload.left_elevon);
               compare_field("right_elevon", want.right_elevon, rsp_payload.right_elevon);
               compare_field("left_elevon_cmd", want.left_elevon_cmd,
                             rsp_payload.left_elevon_cmd);
               compare_field("right_elevon_cmd", want.right_elevon_cmd,
                             rsp_payload.right_elevon_cmd);
            end
            results_checked++;
         end
         rsp_stall <= (burst_left != 0) || ($urandom_range(99) < receiver_idle_pct);
      end
   end

   // Counts out a long receiver hold-off each time one is requested.
   always @(posedge clock) begin
      if (reset) begin
         burst_left <= 0;
         burst_seen <= 0;
      end else if (burst_request != burst_seen) begin
         burst_left <= BURST_CYCLES;
         burst_seen <= burst_request;
      end else if (burst_left != 0) begin
         burst_left <= burst_left - 1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers.
   // ---------------------------------------------------------------------

   // Writes one register and mirrors it into the local copy once the transfer happens.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_DYNAMICS_MODE:  cfg_mode       = value[0];
         CSR_POSITION_LIMIT: cfg_pos_limit  = longint'(value);
         CSR_RATE_LIMIT:     cfg_rate_limit = longint'(value);
         CSR_NATURAL_FREQ:   cfg_wn         = longint'(value[15:0]);
         CSR_DAMPING_RATIO:  cfg_zeta       = longint'(value[15:0]);
         CSR_TIME_STEP:      cfg_dt         = longint'(value[23:0]);
         default: ;
      endcase
   endtask

   task automatic load_settings(logic [CSR_DATA_W-1:0] mode, logic [CSR_DATA_W-1:0] plim,
                                logic [CSR_DATA_W-1:0] rlim, logic [CSR_DATA_W-1:0] wn,
                                logic [CSR_DATA_W-1:0] zeta, logic [CSR_DATA_W-1:0] dt);
      write_reg(CSR_DYNAMICS_MODE, mode);
      write_reg(CSR_POSITION_LIMIT, plim);
      write_reg(CSR_RATE_LIMIT, rlim);
      write_reg(CSR_NATURAL_FREQ, wn);
      write_reg(CSR_DAMPING_RATIO, zeta);
      write_reg(CSR_TIME_STEP, dt);
      settings_applied++;
   endtask

   // Registers may change only with nothing queued, nothing offered and nothing owed.
   task automatic wait_until_drained();
      do @(posedge clock);
      while (pending_commands.size() != 0 || req_valid || predicted_deflections.size() != 0);
   endtask

   task automatic set_idling(int stage);
      case (stage)
         0: begin sender_idle_pct = 12; receiver_idle_pct = 61; end
         1: begin sender_idle_pct = 61; receiver_idle_pct = 12; end
         default: begin sender_idle_pct = 0; receiver_idle_pct = 0; end
      endcase
   endtask

   function automatic logic signed [DATA_W-1:0] near_deflection();
      return DATA_W'(int'($urandom_range(2 * NEAR_SPAN)) - NEAR_SPAN);
   endfunction

   // Either a command inside a realistic deflection range or raw 32-bit noise.
   function automatic req_type make_command(bit full_range);
      req_type c;
      if (full_range) begin
         c.aileron_cmd  = $urandom();
         c.elevator_cmd = $urandom();
         c.rudder_cmd   = $urandom();
      end else begin
         c.aileron_cmd  = near_deflection();
         c.elevator_cmd = near_deflection();
         c.rudder_cmd   = near_deflection();
      end
      return c;
   endfunction

   function automatic req_type command_of(int ail, int elv, int rud);
      req_type c;
      c.aileron_cmd  = ail;
      c.elevator_cmd = elv;
      c.rudder_cmd   = rud;
      return c;
   endfunction

   // Extremes of every field, plus zero and unit values, pushed as one directed group.
   task automatic queue_extremes();
      pending_commands.push_back(command_of(32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
      pending_commands.push_back(command_of(32'h80000000, 32'h80000000, 32'h80000000));
      pending_commands.push_back(command_of(32'h7fffffff, 32'h80000000, 32'h80000000));
      pending_commands.push_back(command_of(32'h80000000, 32'h7fffffff, 32'h7fffffff));
      pending_commands.push_back(command_of(0, 0, 0));
      pending_commands.push_back(command_of(-1, 1, -1));
   endtask

   // ---------------------------------------------------------------------
   // Main sequence.
   // ---------------------------------------------------------------------
   initial begin
      req_type step_cmd;
      int      remaining;
      int      hold;

      set_idling(0);
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Registers at their reset values: clamp mode with a zero limit pins
      // every surface to zero while the elevon mix still saturates.
      queue_extremes();
      wait_until_drained();

      // Widest limit: only the most negative word gets clamped, by one count.
      write_reg(CSR_POSITION_LIMIT, {CSR_DATA_W{1'b1}});
      queue_extremes();
      wait_until_drained();

      // Dynamics with plausible airframe numbers: a small step, then commands
      // past the position limit, then full-scale commands to hit the rate limit.
      load_settings(CSR_DATA_W'(MODE_DYNAMICS), CSR_DATA_W'(30 * DEG),
                    CSR_DATA_W'(300 * DEG), CSR_DATA_W'(20 << 8), CSR_DATA_W'(2867),
                    CSR_DATA_W'(16777));
      repeat (4) pending_commands.push_back(command_of(0, 10 * DEG, -10 * DEG));
      repeat (3) pending_commands.push_back(command_of(40 * DEG, 0, 45 * DEG));
      repeat (3) pending_commands.push_back(command_of(32'h7fffffff, 32'h80000000,
                                                       32'h80000000));
      wait_until_drained();

      // Indexes past the last register must be ignored.
      for (int ix = int'(CSR_TIME_STEP) + 1; ix < (1 << CSR_IDX_W); ix++)
         write_reg(CSR_IDX_W'(ix), {CSR_DATA_W{1'b1}});

      for (int phase = 0; phase < SETTING_COUNT; phase++) begin
         set_idling(phase / 4);
         case (phase % 6)
            0, 2: load_settings(CSR_DATA_W'(MODE_DYNAMICS),
                                CSR_DATA_W'($urandom_range(5, 45) * DEG),
                                CSR_DATA_W'($urandom_range(50, 600) * DEG),
                                CSR_DATA_W'($urandom_range(2 << 8, 60 << 8)),
                                CSR_DATA_W'($urandom_range(819, 6144)),
                                CSR_DATA_W'($urandom_range(3355, 83886)));
            1: load_settings({CSR_DATA_W{1'b1}}, {CSR_DATA_W{1'b1}}, {CSR_DATA_W{1'b1}},
                             {CSR_DATA_W{1'b1}}, {CSR_DATA_W{1'b1}}, {CSR_DATA_W{1'b1}});
            3: load_settings(CSR_DATA_W'(MODE_CLAMP),
                             CSR_DATA_W'(($urandom_range(1) != 0) ? $urandom()
                                                               : $urandom_range(80 * DEG)),
                             CSR_DATA_W'($urandom()), CSR_DATA_W'($urandom()),
                             CSR_DATA_W'($urandom()), CSR_DATA_W'($urandom()));
            4: load_settings(CSR_DATA_W'($urandom()), CSR_DATA_W'($urandom()),
                             CSR_DATA_W'($urandom()), CSR_DATA_W'($urandom()),
                             CSR_DATA_W'($urandom()), CSR_DATA_W'($urandom()));
            default: load_settings(CSR_DATA_W'(MODE_DYNAMICS), '0, '0, '0, '0, '0);
         endcase

         // Mostly held step commands so the lag has time to respond, with
         // some raw full-range words mixed in.
         remaining = ITEMS_PER_SETTING;
         while (remaining > 0) begin
            if ($urandom_range(9) < 2) begin
               pending_commands.push_back(make_command(1'b1));
               remaining--;
            end else begin
               step_cmd = make_command(1'b0);
               hold = $urandom_range(1, 12);
               for (int k = 0; k < hold && remaining > 0; k++) begin
                  pending_commands.push_back(step_cmd);
                  remaining--;
               end
            end
         end

         // In the first clamp-mode phase, stop taking results for a long stretch
         // while the commands keep coming, so the block backs up into its input.
         if (phase == 3) burst_request <= burst_request + 1;
         wait_until_drained();
      end

      // Everything has been offered and answered; allow stray late results to show.
      while (predicted_deflections.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d commands under %0d register settings in clamp and dynamics modes,",
               commands_accepted, settings_applied);
      $display("%0d results checked, %0d errors", results_checked, error_count);
      if (error_count == 0 && predicted_deflections.size() == 0) begin
         $display("second_order_fin_actuator verification clean");
      end else begin
         $display("second_order_fin_actuator verification failed");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #RUN_LIMIT;
      $display("timeout with %0d results still outstanding", predicted_deflections.size());
      $display("second_order_fin_actuator verification failed");
      $finish;
   end

endmodule
